/* rtl/spmc_pkg.sv */
`timescale 1ns / 1ps
package spmc_pkg;
   localparam int DefMaxPattern = 32;
   localparam int DefCountWidth = 32;
   localparam int PatternWords  = 4;
   localparam int PatternBytes  = PatternWords * 8;
   localparam logic [7:0] NewlineByte = 8'h0A;

   localparam logic [2:0] CSR_WORD0 = 3'd0;
   localparam logic [2:0] CSR_WORD3 = 3'd3;
   localparam logic [2:0] CSR_LENGTH = 3'd4;
   localparam logic [2:0] CSR_MODE = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_file;
   } req_type;

   typedef struct packed {
      logic [31:0] lines_seen;
      logic [31:0] matches_counted;
      logic        match_here;
      logic        stopped;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic first;
      logic newline;
      logic hit;
   } cls_type;
endpackage

/* rtl/spmc_front.sv */
`timescale 1ns / 1ps
module spmc_front
   import spmc_pkg::*;
#(
   parameter int MAX_PATTERN = DefMaxPattern
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  req_type                     in_item,
   output logic                        in_ready,
   input  logic [PatternBytes*8-1:0]   pattern,
   input  logic [5:0]                  length_cfg,
   input  logic                        unique_mode,
   output logic                        out_valid,
   output cls_type                     out_cls,
   input  logic                        out_ready
);
   localparam int FW = $clog2(MAX_PATTERN + 1);

   logic [7:0]    window_ff [MAX_PATTERN];
   logic [FW-1:0] fill_ff, fill_in;
   logic          stop_ff, stop_in;
   logic          valid_ff;
   cls_type       cls_ff;
   logic [FW-1:0] len;
   logic [FW-1:0] fill_base;
   logic [FW-1:0] fill_next;
   logic          hit;
   logic          stop_base;
   logic          take;
   logic [7:0]    win_next [MAX_PATTERN];

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_cls   = cls_ff;

   always_comb begin
      if (length_cfg == 6'd0) begin
         len = FW'(1);
      end else if (32'(length_cfg) > MAX_PATTERN) begin
         len = FW'(MAX_PATTERN);
      end else begin
         len = FW'(length_cfg);
      end
   end

   always_comb begin
      fill_base = in_item.first_of_file ? '0 : fill_ff;
      stop_base = in_item.first_of_file ? 1'b0 : stop_ff;
      win_next[0] = in_item.data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         win_next[i] = window_ff[i-1];
      end
      fill_next = (32'(fill_base) < MAX_PATTERN) ? fill_base + FW'(1) : fill_base;
      hit = !stop_base && (fill_next >= len);
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (k < 32'(len)) begin
            if (win_next[32'(len) - 1 - k] !=
                ((k < PatternBytes) ? pattern[(k % PatternBytes)*8 +: 8] : 8'h00)) begin
               hit = 1'b0;
            end
         end
      end
      fill_in = fill_ff;
      stop_in = stop_base;
      if (!stop_base) begin
         fill_in = hit ? '0 : fill_next;
         if (hit && !unique_mode) begin
            stop_in = 1'b1;
         end
      end else begin
         fill_in = fill_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         stop_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            fill_ff <= fill_in;
            stop_ff <= stop_in;
         end
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (!stop_base) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
               window_ff[i] <= win_next[i];
            end
         end
         cls_ff.first   <= in_item.first_of_file;
         cls_ff.newline <= !stop_base && (in_item.data_byte == NewlineByte);
         cls_ff.hit     <= hit;
      end
   end
endmodule

/* rtl/spmc_back.sv */
`timescale 1ns / 1ps
module spmc_back
   import spmc_pkg::*;
#(
   parameter int COUNT_WIDTH = DefCountWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  cls_type in_cls,
   output logic    in_ready,
   input  logic    unique_mode,
   output logic    out_valid,
   output rsp_type out_item,
   input  logic    out_ready
);
   localparam logic [COUNT_WIDTH-1:0] Limit = '1;

   logic [COUNT_WIDTH-1:0] lines_ff, lines_in;
   logic [COUNT_WIDTH-1:0] match_ff, match_in;
   logic [COUNT_WIDTH-1:0] last_ff, last_in;
   logic                   have_ff, have_in;
   logic                   stop_ff, stop_in;
   logic                   valid_ff;
   rsp_type                item_ff;
   logic                   take;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      lines_in = in_cls.first ? '0 : lines_ff;
      match_in = in_cls.first ? '0 : match_ff;
      last_in  = in_cls.first ? '0 : last_ff;
      have_in  = in_cls.first ? 1'b0 : have_ff;
      stop_in  = in_cls.first ? 1'b0 : stop_ff;
      if (in_cls.newline && lines_in != Limit) begin
         lines_in = lines_in + 1'b1;
      end
      if (in_cls.hit) begin
         if (unique_mode) begin
            if (!have_in || last_in != lines_in) begin
               if (match_in != Limit) begin
                  match_in = match_in + 1'b1;
               end
               last_in = lines_in;
               have_in = 1'b1;
            end
         end else begin
            stop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff <= '0;
         match_ff <= '0;
         last_ff  <= '0;
         have_ff  <= 1'b0;
         stop_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            lines_ff <= lines_in;
            match_ff <= match_in;
            last_ff  <= last_in;
            have_ff  <= have_in;
            stop_ff  <= stop_in;
         end
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.lines_seen      <= 32'(64'(lines_in));
         item_ff.matches_counted <= 32'(64'(match_in));
         item_ff.match_here      <= in_cls.hit;
         item_ff.stopped         <= stop_in;
      end
   end
endmodule

/* rtl/stream_pattern_match_counter.sv */
`timescale 1ns / 1ps
// Streaming fixed-pattern search: one text byte per item, one result per item,
// one item per cycle sustained while rsp_ready is held high. The front stage compares
// the newest configured-length bytes of the window with the pattern in parallel; the back
// stage updates the line and match counters. Each stage holds one item.
module stream_pattern_match_counter
   import spmc_pkg::*;
#(
   parameter int MAX_PATTERN = DefMaxPattern,
   parameter int COUNT_WIDTH = DefCountWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [PatternBytes*8-1:0] pattern_ff;
   logic [5:0]                length_ff;
   logic                      mode_ff;
   logic                      mid_valid, mid_ready;
   cls_type                   mid_cls;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= 6'd1;
         mode_ff    <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index <= CSR_WORD3) begin
            pattern_ff[csr_index[1:0]*64 +: 64] <= csr_data;
         end else if (csr_index == CSR_LENGTH) begin
            length_ff <= csr_data[5:0];
         end else if (csr_index == CSR_MODE) begin
            mode_ff <= csr_data[0];
         end
      end
   end

   spmc_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_item(req_item), .in_ready(req_ready),
      .pattern(pattern_ff), .length_cfg(length_ff), .unique_mode(mode_ff),
      .out_valid(mid_valid), .out_cls(mid_cls), .out_ready(mid_ready)
   );

   spmc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock, .reset,
      .in_valid(mid_valid), .in_cls(mid_cls), .in_ready(mid_ready),
      .unique_mode(mode_ff),
      .out_valid(rsp_valid), .out_item(rsp_item), .out_ready(rsp_ready)
   );
endmodule
